### src/cfir_pkg.sv
// ----------------------------------------------------------------------------
// cfir_pkg: shared definitions for the complex FIR filter
// Sizes, opcodes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package cfir_pkg;

	localparam int TAPS        = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 18;

	localparam int NT_W     = 7;
	localparam int IDX_W    = 6;
	localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W    = PROD_W + $clog2(TAPS);
	localparam int FRAC     = COEF_BITS - 1;
	localparam int CNT_W    = $clog2(TAPS + 2);

	localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(TAPS + 1);
	localparam logic [NT_W-1:0]  NT_RESET = NT_W'(TAPS);

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_LOAD   = 2'd1,
		OP_CLEAR  = 2'd2
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

### src/complex_fir_filter.sv
// ----------------------------------------------------------------------------
// complex_fir_filter: direct-form FIR on complex samples, real coefficients
// Row of 64 tap cells with a partial-sum chain and a round/saturate output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, coef_index, coef_value,
//   sample_i and sample_q. A load transaction writes one coefficient, a clear
//   transaction zeroes the sample history; both give no result. A filter
//   transaction shifts the history and yields one out_i/out_q transaction on
//   the output channel (out_valid/out_ready). The user must write num_taps
//   (cfg_wr_en/cfg_wr_data) only while the block is idle; it is not enforced.
// Operation:
//   A filter item is accepted, its products are registered, and the partial
//   sum then walks the cell row one tap per cycle until it leaves the last
//   cell. No new item is taken until the result is in the output register,
//   so filter items never overlap.
// Reset:
//   Coefficients and history clear to zero, num_taps returns to 64, no result
//   is pending.
// Receiver stall:
//   The result waits in the output register; a following load or clear is
//   still taken, a following filter item finishes and then waits in the
//   controller until the output register is free.
// ----------------------------------------------------------------------------
module complex_fir_filter import cfir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [NT_W-1:0]               cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [IDX_W-1:0]              coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q
);

	logic [NT_W-1:0]  num_taps_q;
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             in_fire;
	logic             out_load;
	logic             slot_free;
	cell_ctrl_t       cell_ctrl;

	logic [TAPS-1:0]               coef_we;
	logic [TAPS-1:0]               tap_en;
	logic signed [SAMPLE_BITS-1:0] x_i_c [TAPS];
	logic signed [SAMPLE_BITS-1:0] x_q_c [TAPS];
	logic signed [ACC_W-1:0]       sum_i_c [TAPS];
	logic signed [ACC_W-1:0]       sum_q_c [TAPS];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	assign cell_ctrl.shift = in_fire && (opcode == OP_FILTER);
	assign cell_ctrl.clear = in_fire && (opcode == OP_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NT_RESET;
		end else if (cfg_wr_en) begin
			num_taps_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (opcode == OP_FILTER)) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				if (cnt_q != RUN_LAST) begin
					cnt_d = cnt_q + 1'b1;
				end else if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_tap
			assign coef_we[k] = in_fire && (opcode == OP_LOAD) && (int'(coef_index) == k);
			assign tap_en[k]  = int'(num_taps_q) > k;

			if (k == 0) begin : g_head
				cfir_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (cell_ctrl),
					.coef_we    (coef_we[k]),
					.coef_wdata (coef_value),
					.tap_en     (tap_en[k]),
					.x_i_in     (sample_i),
					.x_q_in     (sample_q),
					.x_i        (x_i_c[k]),
					.x_q        (x_q_c[k]),
					.sum_i_in   ('0),
					.sum_q_in   ('0),
					.sum_i      (sum_i_c[k]),
					.sum_q      (sum_q_c[k])
				);
			end else begin : g_body
				cfir_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (cell_ctrl),
					.coef_we    (coef_we[k]),
					.coef_wdata (coef_value),
					.tap_en     (tap_en[k]),
					.x_i_in     (x_i_c[k-1]),
					.x_q_in     (x_q_c[k-1]),
					.x_i        (x_i_c[k]),
					.x_q        (x_q_c[k]),
					.sum_i_in   (sum_i_c[k-1]),
					.sum_q_in   (sum_q_c[k-1]),
					.sum_i      (sum_i_c[k]),
					.sum_q      (sum_q_c[k])
				);
			end
		end
	endgenerate

	cfir_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.acc_i     (sum_i_c[TAPS-1]),
		.acc_q     (sum_q_c[TAPS-1]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_i     (out_i),
		.out_q     (out_q)
	);

`ifndef SYNTHESIS
	// a result never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> slot_free)
		else $error("result loaded while output register is full");

	// results appear only once the sum has crossed the whole row
	a_load_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == ST_RUN) && (cnt_q == RUN_LAST))
		else $error("result loaded before the partial sum settled");

	a_filter_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (opcode == OP_FILTER)) |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("filter transaction did not start a run");

	a_other_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (opcode != OP_FILTER)) |=> (state_q == ST_IDLE) && !$rose(out_valid))
		else $error("non-filter transaction started a run or a result");
`endif

endmodule

### src/cfir_cell.sv
// ----------------------------------------------------------------------------
// cfir_cell: one tap of the filter
// Holds a coefficient and one I/Q history sample, forms the tap products and
// adds them into the partial sums passed along the row.
// ----------------------------------------------------------------------------
module cfir_cell import cfir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctrl_t                    ctrl,
	input  logic                          coef_we,
	input  logic signed [COEF_BITS-1:0]   coef_wdata,
	input  logic                          tap_en,
	input  logic signed [SAMPLE_BITS-1:0] x_i_in,
	input  logic signed [SAMPLE_BITS-1:0] x_q_in,
	output logic signed [SAMPLE_BITS-1:0] x_i,
	output logic signed [SAMPLE_BITS-1:0] x_q,
	input  logic signed [ACC_W-1:0]       sum_i_in,
	input  logic signed [ACC_W-1:0]       sum_q_in,
	output logic signed [ACC_W-1:0]       sum_i,
	output logic signed [ACC_W-1:0]       sum_q
);

	logic signed [COEF_BITS-1:0]   coef_q;
	logic signed [SAMPLE_BITS-1:0] x_i_q;
	logic signed [SAMPLE_BITS-1:0] x_q_q;
	logic signed [PROD_W-1:0]      mul_i;
	logic signed [PROD_W-1:0]      mul_q;
	logic signed [PROD_W-1:0]      prod_i_q;
	logic signed [PROD_W-1:0]      prod_q_q;
	logic signed [ACC_W-1:0]       sum_i_q;
	logic signed [ACC_W-1:0]       sum_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			x_i_q  <= '0;
			x_q_q  <= '0;
		end else begin
			if (coef_we)
				coef_q <= coef_wdata;
			if (ctrl.clear) begin
				x_i_q <= '0;
				x_q_q <= '0;
			end else if (ctrl.shift) begin
				x_i_q <= x_i_in;
				x_q_q <= x_q_in;
			end
		end
	end

	// signed products at full width, kept apart from the tap-enable select
	assign mul_i = PROD_W'(coef_q) * PROD_W'(x_i_q);
	assign mul_q = PROD_W'(coef_q) * PROD_W'(x_q_q);

	// products and partial sums move every cycle; the controller knows when
	// the far end of the row has settled
	always_ff @(posedge clk) begin
		prod_i_q <= tap_en ? mul_i : '0;
		prod_q_q <= tap_en ? mul_q : '0;
		sum_i_q  <= sum_i_in + {{(ACC_W-PROD_W){prod_i_q[PROD_W-1]}}, prod_i_q};
		sum_q_q  <= sum_q_in + {{(ACC_W-PROD_W){prod_q_q[PROD_W-1]}}, prod_q_q};
	end

	assign x_i   = x_i_q;
	assign x_q   = x_q_q;
	assign sum_i = sum_i_q;
	assign sum_q = sum_q_q;

endmodule

### src/cfir_out.sv
// ----------------------------------------------------------------------------
// cfir_out: rounding, saturation and output register
// Rounds the accumulated sums half up, drops the fraction bits, clips to the
// sample range and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module cfir_out import cfir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [ACC_W-1:0]       acc_i,
	input  logic signed [ACC_W-1:0]       acc_q,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q
);

	localparam logic signed [ACC_W:0] RND_HALF =
		{{(ACC_W+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [ACC_W:0] SAT_MAX =
		{{(ACC_W+2-SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W:0] SAT_MIN =
		{{(ACC_W+2-SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc
	);
		logic signed [ACC_W:0] rnd;
		logic signed [ACC_W:0] shf;
		logic signed [SAMPLE_BITS-1:0] res;
		rnd = $signed({acc[ACC_W-1], acc}) + RND_HALF;
		shf = rnd >>> FRAC;
		if (shf > SAT_MAX)
			res = SAT_MAX[SAMPLE_BITS-1:0];
		else if (shf < SAT_MIN)
			res = SAT_MIN[SAMPLE_BITS-1:0];
		else
			res = shf[SAMPLE_BITS-1:0];
		return res;
	endfunction

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_i_q;
	logic signed [SAMPLE_BITS-1:0] out_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_i_q <= round_sat(acc_i);
			out_q_q <= round_sat(acc_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_i     = out_i_q;
	assign out_q     = out_q_q;

endmodule
